[sv/b64lw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, constants and the sextet-to-ASCII mapping of the
// line-wrapped base64 encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

  localparam int GroupsPerLineDef = 19;

  localparam logic [7:0] CharCr  = 8'h0d;
  localparam logic [7:0] CharLf  = 8'h0a;
  localparam logic [7:0] CharPad = 8'h3d;  // '='

  // Characters produced by one input byte, emitted from index 0 upwards.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;  // index of the final character of the set
    logic            msg_end;   // set holds the end of the encoded message
  } bundle_t;

  // Map a six-bit value onto the standard base64 alphabet.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h2f;  // '/'
    priority if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2b;  // '+'
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

endpackage

[sv/b64lw_encode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_encode
// Group state and the single-pass mapping of one byte to its characters.
// ----------------------------------------------------------------------------
module b64lw_encode #(
  parameter int GROUPS_PER_LINE = b64lw_pkg::GroupsPerLineDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [7:0]         data_byte_i,
  input  logic               final_byte_i,
  output b64lw_pkg::bundle_t bundle_o
);

  localparam logic [4:0] LineGroups = 5'(GROUPS_PER_LINE);

  logic [3:0] leftover_q, leftover_d;
  logic [1:0] phase_q, phase_d;
  logic [4:0] groups_q, groups_d;
  logic [4:0] groups_inc;

  always_comb begin
    bundle_o         = '0;
    bundle_o.msg_end = final_byte_i;
    leftover_d       = leftover_q;
    phase_d          = phase_q;
    groups_d         = groups_q;
    groups_inc       = groups_q + 5'd1;
    unique case (phase_q)
      2'd1: begin
        bundle_o.chars[0] = b64lw_pkg::sextet_char({leftover_q[1:0], data_byte_i[7:4]});
        bundle_o.last_idx = 2'd0;
        leftover_d        = data_byte_i[3:0];
        phase_d           = 2'd2;
        if (final_byte_i) begin
          bundle_o.chars[1] = b64lw_pkg::sextet_char({data_byte_i[3:0], 2'b00});
          bundle_o.chars[2] = b64lw_pkg::CharPad;
          bundle_o.last_idx = 2'd2;
        end
      end
      2'd2: begin
        bundle_o.chars[0] = b64lw_pkg::sextet_char({leftover_q, data_byte_i[7:6]});
        bundle_o.chars[1] = b64lw_pkg::sextet_char(data_byte_i[5:0]);
        bundle_o.last_idx = 2'd1;
        leftover_d        = 4'd0;
        phase_d           = 2'd0;
        groups_d          = groups_inc;
        if (groups_inc >= LineGroups) begin
          bundle_o.chars[2] = b64lw_pkg::CharCr;
          bundle_o.chars[3] = b64lw_pkg::CharLf;
          bundle_o.last_idx = 2'd3;
          groups_d          = 5'd0;
        end
      end
      default: begin
        bundle_o.chars[0] = b64lw_pkg::sextet_char(data_byte_i[7:2]);
        bundle_o.last_idx = 2'd0;
        leftover_d        = {2'b00, data_byte_i[1:0]};
        phase_d           = 2'd1;
        if (final_byte_i) begin
          bundle_o.chars[1] = b64lw_pkg::sextet_char({data_byte_i[1:0], 4'b0000});
          bundle_o.chars[2] = b64lw_pkg::CharPad;
          bundle_o.chars[3] = b64lw_pkg::CharPad;
          bundle_o.last_idx = 2'd3;
        end
      end
    endcase
    // end of message: start the next one afresh
    if (final_byte_i) begin
      leftover_d = 4'd0;
      phase_d    = 2'd0;
      groups_d   = 5'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leftover_q <= 4'd0;
      phase_q    <= 2'd0;
      groups_q   <= 5'd0;
    end else if (load_i) begin
      leftover_q <= leftover_d;
      phase_q    <= phase_d;
      groups_q   <= groups_d;
    end
  end

  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("group phase left its range");

  a_line_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    groups_q < LineGroups)
    else $error("line group count reached the line length");

  a_group_start_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == 2'd0 |-> leftover_q == 4'd0)
    else $error("leftover bits held at the start of a group");

endmodule

[sv/b64lw_serial.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_serial
// Character set register; emits its characters one per cycle while out_stall_i is low.
// ----------------------------------------------------------------------------
module b64lw_serial (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  b64lw_pkg::bundle_t bundle_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_char_o,
  output logic               out_last_o
);

  b64lw_pkg::bundle_t bundle_q;
  logic               busy_q;
  logic [1:0]         idx_q;
  logic               take;
  logic               at_last;

  assign take    = busy_q && !out_stall_i;
  assign at_last = idx_q == bundle_q.last_idx;
  assign free_o  = !busy_q || (take && at_last);

  assign out_valid_o = busy_q;
  assign out_char_o  = bundle_q.chars[idx_q];
  assign out_last_o  = bundle_q.msg_end && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (take) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= bundle_q.last_idx)
    else $error("character index beyond the held set");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("set loaded over characters not yet sent");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && at_last && !load_i) |=> !busy_q)
    else $error("register still busy after its last character");

endmodule

[sv/base64_line_wrapped_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// Byte-at-a-time base64 encoder with CR LF after every full line of groups.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one message byte per
//   request, with final_byte_i set on the last byte of the message.
//   Output channel (out_valid_o / out_stall_i) carries one ASCII character
//   per request; out_last_o marks the last character of the message.
//   A byte produces one to four characters: its base64 characters, '='
//   padding at a short final group, and CR LF after each line of
//   GROUPS_PER_LINE complete groups (76 characters by default).
// Path: a byte that is taken passes the input register, then the character
//   set register, on its way to its first character.
// Flow: the character set register, read out one character a cycle while
//   out_stall_i is low, paces the input; the input register can hold the
//   next byte while the current set drains.
// Reset: clears both registers' valid flags and the group state; the
//   next byte starts a new message. A final byte clears the group state too.
// Stall: while out_stall_i is high the current character holds; one byte
//   more waits in the input register, then in_stall_o rises.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder #(
  parameter int GROUPS_PER_LINE = b64lw_pkg::GroupsPerLineDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  logic               in_valid_q;
  logic [7:0]         data_q;
  logic               final_q;
  logic               set_free;
  logic               load;
  logic               accept;
  b64lw_pkg::bundle_t bundle;

  // Hold the input register while the character set register is occupied.
  assign in_stall_o = in_valid_q && !set_free;
  assign accept     = in_valid_i && !in_stall_o;
  // Advance the held byte into the set register as soon as it frees up.
  assign load       = in_valid_q && set_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  // Payload register: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q  <= data_byte_i;
      final_q <= final_byte_i;
    end
  end

  // Byte to characters, with the group and line state.
  b64lw_encode #(
    .GROUPS_PER_LINE(GROUPS_PER_LINE)
  ) u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .data_byte_i (data_q),
    .final_byte_i(final_q),
    .bundle_o    (bundle)
  );

  // Character set register and output sequencing.
  b64lw_serial u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .bundle_i   (bundle),
    .free_o     (set_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_char_o (out_char_o),
    .out_last_o (out_last_o)
  );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line-wrapped base64 encoder: a short table of
// hand-picked bytes, then random messages (some long enough to wrap lines),
// each output character checked against a hand-written expectation or a cycle-free encoding predictor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GroupsPerLine = b64lw_pkg::GroupsPerLineDef;
  localparam int RandomBytes   = 248;   // on top of the directed table
  localparam int IdleLimit     = 2000;  // cycles with no transfer on either side

  // One expected output character.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  // Characters caused by one input byte, index 0 first.
  typedef struct packed {
    logic [3:0][7:0] ch;
    logic [2:0]      cnt;
    logic            fin;
  } char_set_t;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    bit         typed;  // expectation written out by hand
    char_set_t  want;
  } stim_row_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i  = 8'h00;
  logic       final_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [7:0] out_char_o;
  logic       out_last_o;

  string base64_digits =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Predictor state: bits carried over, slot of next byte, groups on line.
  logic [3:0] held_bits   = '0;
  logic [1:0] byte_slot   = '0;
  logic [4:0] line_groups = '0;

  enc_char_t  expected_chars[$];
  stim_row_t  directed_rows[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  bit         burst_mode = 1'b0;

  base64_line_wrapped_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .out_last_o   (out_last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [7:0] digit_char(input logic [5:0] v);
    return base64_digits[v];
  endfunction

  // Encode one byte and advance the predictor state.
  function automatic char_set_t predict_chars(input logic [7:0] b, input logic fin);
    char_set_t s;
    s = '0;
    unique case (byte_slot)
      2'd1: begin
        s.ch[0] = digit_char({held_bits[1:0], b[7:4]});
        s.cnt = 3'd1;
        held_bits = b[3:0];
        byte_slot = 2'd2;
        if (fin) begin
          s.ch[1] = digit_char({held_bits, 2'b00});
          s.ch[2] = b64lw_pkg::CharPad;
          s.cnt = 3'd3;
        end
      end
      2'd2: begin
        s.ch[0] = digit_char({held_bits, b[7:6]});
        s.ch[1] = digit_char(b[5:0]);
        s.cnt = 3'd2;
        held_bits = '0;
        byte_slot = 2'd0;
        line_groups = line_groups + 5'd1;
        // close the line once it holds a full count of groups
        if (line_groups >= GroupsPerLine) begin
          s.ch[2] = b64lw_pkg::CharCr;
          s.ch[3] = b64lw_pkg::CharLf;
          s.cnt = 3'd4;
          line_groups = '0;
        end
      end
      default: begin
        // slot 0; an out-of-range slot is treated the same way
        s.ch[0] = digit_char(b[7:2]);
        s.cnt = 3'd1;
        held_bits = {2'b00, b[1:0]};
        byte_slot = 2'd1;
        if (fin) begin
          s.ch[1] = digit_char({b[1:0], 4'b0000});
          s.ch[2] = b64lw_pkg::CharPad;
          s.ch[3] = b64lw_pkg::CharPad;
          s.cnt = 3'd4;
        end
      end
    endcase
    s.fin = fin;
    // end of message: start afresh on the next byte
    if (fin) begin
      held_bits = '0;
      byte_slot = '0;
      line_groups = '0;
    end
    return s;
  endfunction

  function automatic char_set_t spelled(input int cnt, input logic fin,
                                        input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic [7:0] c3);
    char_set_t s;
    s.ch  = {c3, c2, c1, c0};
    s.cnt = 3'(cnt);
    s.fin = fin;
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic void add_row(input logic [7:0] d, input logic f, input bit typed,
                                  input char_set_t want);
    stim_row_t row;
    row.data  = d;
    row.fin   = f;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Present one request, hold it until taken, then record what it should cause.
  task automatic send_byte(input logic [7:0] d, input logic f, input bit typed,
                           input char_set_t want);
    char_set_t got;
    enc_char_t c;
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    data_byte_i  <= d;
    final_byte_i <= f;
    do @(posedge clk_i); while (in_stall_o);
    got = predict_chars(d, f);
    if (typed) got = want;
    for (int i = 0; i < got.cnt; i++) begin
      c.ch   = got.ch[i];
      c.last = got.fin && (i == got.cnt - 1);
      expected_chars.push_back(c);
    end
  endtask

  // Output side: alternate stretches of stall and of free flow.
  initial begin
    int n;
    forever begin
      n = pick_gap();
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check each character taken from the output against the oldest expectation.
  always @(posedge clk_i) begin
    enc_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: out_char=%h out_last=%b", out_char_o, out_last_o);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char_o !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_char_o);
          mismatches++;
        end
        if (out_last_o !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_last_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    stim_row_t row;
    int sent;
    int len;
    int msg;
    logic [7:0] d;

    // Single-byte messages at both extremes: two digits and double padding.
    add_row(8'h00, 1'b1, 1'b1, spelled(4, 1'b1, "A", "A", b64lw_pkg::CharPad,
                                       b64lw_pkg::CharPad));
    add_row(8'hff, 1'b1, 1'b1, spelled(4, 1'b1, "/", "w", b64lw_pkg::CharPad,
                                       b64lw_pkg::CharPad));
    // Two-byte message: single padding.
    add_row(8'h00, 1'b0, 1'b1, spelled(1, 1'b0, "A", 8'h00, 8'h00, 8'h00));
    add_row(8'h00, 1'b1, 1'b1, spelled(3, 1'b1, "A", "A", b64lw_pkg::CharPad, 8'h00));
    // Full group of ones: no padding, no line break.
    add_row(8'hff, 1'b0, 1'b1, spelled(1, 1'b0, "/", 8'h00, 8'h00, 8'h00));
    add_row(8'hff, 1'b0, 1'b1, spelled(1, 1'b0, "/", 8'h00, 8'h00, 8'h00));
    add_row(8'hff, 1'b1, 1'b1, spelled(2, 1'b1, "/", "/", 8'h00, 8'h00));
    // Remaining rows go through the predictor.
    add_row(8'h4d, 1'b0, 1'b0, '0);
    add_row(8'h61, 1'b0, 1'b0, '0);
    add_row(8'h6e, 1'b1, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h7f, 1'b1, 1'b0, '0);
    add_row(8'h3f, 1'b0, 1'b0, '0);
    add_row(8'hc0, 1'b1, 1'b0, '0);
    add_row(8'h55, 1'b0, 1'b0, '0);
    add_row(8'haa, 1'b0, 1'b0, '0);
    add_row(8'h0f, 1'b0, 1'b0, '0);
    add_row(8'hf0, 1'b1, 1'b0, '0);
    add_row(8'hfe, 1'b0, 1'b0, '0);
    add_row(8'hfd, 1'b1, 1'b0, '0);
    add_row(8'h01, 1'b1, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_byte(row.data, row.fin, row.typed, row.want);
    end

    // Random messages: first one that ends exactly on a full line, then one
    // that wraps mid-message, then mostly short ones with the odd long one.
    sent = 0;
    msg = 0;
    while (sent < RandomBytes) begin
      if (msg == 0) len = 57;
      else if (msg == 1) len = 61;
      else if ($urandom_range(0, 11) == 0) len = $urandom_range(55, 60);
      else len = $urandom_range(1, 9);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 7) == 0) d = $urandom_range(0, 1) ? 8'hff : 8'h00;
        else d = 8'($urandom);
        send_byte(d, k == len - 1, 1'b0, '0);
      end
      sent += len;
      msg++;
    end
    burst_mode = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // drain, then allow a few cycles for any stray character
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
sv/b64lw_pkg.sv
sv/b64lw_encode.sv
sv/b64lw_serial.sv
sv/base64_line_wrapped_encoder.sv
dv/testbench.sv
